/* src/mke_pkg.sv */
// Shared types for the Morse keying encoder: character classes, queue entry, sequencer states.
package mke_pkg;

    // Character class decided by the front end
    typedef enum logic [1:0] {
        K_SYMBOL = 2'd0,
        K_SPACE  = 2'd1,
        K_OTHER  = 2'd2
    } t_kind;

    // One classified character waiting for the back end.
    // pat bit j is 1 for a dash at symbol position j, sent from bit 0 up.
    typedef struct packed {
        t_kind      kind;
        logic [2:0] len;
        logic [4:0] pat;
        logic       eom;
    } t_entry;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SYM   = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    // ASCII anchors used by the classifier
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Reset value of the dot unit in ms
    localparam logic [15:0] DOT_UNIT_RESET = 16'd100;

endpackage

/* src/mke_front.sv */
// Front end: accepts characters, looks up their Morse code and pushes them into the queue.
module mke_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] char_code
    input  logic           s_axis_tlast,   // end_of_message
    // queue push side
    output logic           o_push,
    output mke_pkg::t_entry o_entry,
    input  logic           i_full
);

    // Letter table: symbol count and dash mask, A is index 0
    function automatic logic [7:0] alpha_code(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:    r = {3'd2, 5'b00010};
            5'd1:    r = {3'd4, 5'b00001};
            5'd2:    r = {3'd4, 5'b00101};
            5'd3:    r = {3'd3, 5'b00001};
            5'd4:    r = {3'd1, 5'b00000};
            5'd5:    r = {3'd4, 5'b00100};
            5'd6:    r = {3'd3, 5'b00011};
            5'd7:    r = {3'd4, 5'b00000};
            5'd8:    r = {3'd2, 5'b00000};
            5'd9:    r = {3'd4, 5'b01110};
            5'd10:   r = {3'd3, 5'b00101};
            5'd11:   r = {3'd4, 5'b00010};
            5'd12:   r = {3'd2, 5'b00011};
            5'd13:   r = {3'd2, 5'b00001};
            5'd14:   r = {3'd3, 5'b00111};
            5'd15:   r = {3'd4, 5'b00110};
            5'd16:   r = {3'd4, 5'b01011};
            5'd17:   r = {3'd3, 5'b00010};
            5'd18:   r = {3'd3, 5'b00000};
            5'd19:   r = {3'd1, 5'b00001};
            5'd20:   r = {3'd3, 5'b00100};
            5'd21:   r = {3'd4, 5'b01000};
            5'd22:   r = {3'd3, 5'b00110};
            5'd23:   r = {3'd4, 5'b01001};
            5'd24:   r = {3'd4, 5'b01101};
            5'd25:   r = {3'd4, 5'b00011};
            default: r = {3'd0, 5'b00000};
        endcase
        return r;
    endfunction

    // Digit table: always five symbols, only the dash mask varies
    function automatic logic [4:0] digit_pat(input logic [3:0] idx);
        logic [4:0] r;
        case (idx)
            4'd0:    r = 5'b11111;
            4'd1:    r = 5'b11110;
            4'd2:    r = 5'b11100;
            4'd3:    r = 5'b11000;
            4'd4:    r = 5'b10000;
            4'd5:    r = 5'b00000;
            4'd6:    r = 5'b00001;
            4'd7:    r = 5'b00011;
            4'd8:    r = 5'b00111;
            4'd9:    r = 5'b01111;
            default: r = 5'b00000;
        endcase
        return r;
    endfunction

    logic [7:0] upper;
    logic       is_alpha;
    logic       is_digit;
    logic [7:0] a_off;
    logic [7:0] d_off;
    logic [7:0] a_code;

    // Fold lower case onto upper case, then classify
    always_comb begin
        if (s_axis_tdata >= mke_pkg::CH_LOWER_A && s_axis_tdata <= mke_pkg::CH_LOWER_Z) begin
            upper = s_axis_tdata - mke_pkg::CASE_DELTA;
        end else begin
            upper = s_axis_tdata;
        end
        is_alpha = (upper >= mke_pkg::CH_UPPER_A) && (upper <= mke_pkg::CH_UPPER_Z);
        is_digit = (s_axis_tdata >= mke_pkg::CH_ZERO) && (s_axis_tdata <= mke_pkg::CH_NINE);
        a_off    = upper - mke_pkg::CH_UPPER_A;
        d_off    = s_axis_tdata - mke_pkg::CH_ZERO;
        a_code   = alpha_code(a_off[4:0]);

        o_entry.eom = s_axis_tlast;
        if (is_alpha) begin
            o_entry.kind = mke_pkg::K_SYMBOL;
            o_entry.len  = a_code[7:5];
            o_entry.pat  = a_code[4:0];
        end else if (is_digit) begin
            o_entry.kind = mke_pkg::K_SYMBOL;
            o_entry.len  = 3'd5;
            o_entry.pat  = digit_pat(d_off[3:0]);
        end else if (s_axis_tdata == mke_pkg::CH_SPACE) begin
            o_entry.kind = mke_pkg::K_SPACE;
            o_entry.len  = 3'd0;
            o_entry.pat  = 5'b00000;
        end else begin
            o_entry.kind = mke_pkg::K_OTHER;
            o_entry.len  = 3'd0;
            o_entry.pat  = 5'b00000;
        end
    end

    // Accept whenever the queue has room, once out of reset
    logic r_rst_seen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_seen <= 1'b0;
        end else begin
            r_rst_seen <= 1'b1;
        end
    end

    assign s_axis_tready = r_rst_seen && !i_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

endmodule

/* src/mke_queue.sv */
// Two-entry queue between the front end and the keying sequencer.
module mke_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mke_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output mke_pkg::t_entry o_entry,
    output logic            o_empty
);

    mke_pkg::t_entry r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rptr];

endmodule

/* src/mke_back.sv */
// Keying sequencer: expands queued characters into mark and gap events with durations.
module mke_back #(
    parameter int DURATION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [15:0]              i_cfg_data,
    // queue pop side
    input  mke_pkg::t_entry          i_entry,
    input  logic                     i_empty,
    output logic                     o_pop,
    // event output
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_mark,
    output logic [DURATION_BITS-1:0] o_duration,
    output logic                     o_last
);

    localparam int DB = DURATION_BITS;
    localparam int SW = ((DB > 19) ? DB : 19) + 1;
    localparam logic [DB-1:0] DUR_MAX = '1;

    function automatic logic [DB-1:0] sat(input logic [SW-1:0] v);
        return (v > SW'(DUR_MAX)) ? DUR_MAX : v[DB-1:0];
    endfunction

    mke_pkg::t_state r_state, n_state;
    mke_pkg::t_entry r_cur,   n_cur;
    logic [2:0]      r_idx,   n_idx;
    logic [DB-1:0]   r_pending, n_pending;
    logic            r_prev,  n_prev;
    logic [15:0]     r_dot_unit;

    logic            r_valid, n_valid;
    logic            r_key,   n_key;
    logic [DB-1:0]   r_dur,   n_dur;
    logic            r_last,  n_last;

    logic            out_free;
    logic [17:0]     u3;
    logic [18:0]     u7;
    logic [18:0]     gap_add;
    logic [SW-1:0]   gap_sum;
    logic            last_sym;
    logic            is_dash;

    // Dot unit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_unit <= mke_pkg::DOT_UNIT_RESET;
        end else if (i_cfg_we) begin
            r_dot_unit <= i_cfg_data;
        end
    end

    // Unit multiples
    assign u3 = {2'b00, r_dot_unit} + {1'b0, r_dot_unit, 1'b0};
    assign u7 = {r_dot_unit, 3'b000} - {3'b000, r_dot_unit};

    assign out_free = !r_valid || i_ready;
    assign last_sym = (r_idx == (r_cur.len - 3'd1));
    assign is_dash  = r_cur.pat[r_idx];

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mke_pkg::ST_IDLE;
            r_pending <= '0;
            r_prev    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_prev    <= n_prev;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_dur  <= n_dur;
        r_last <= n_last;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_pending = r_pending;
        n_prev    = r_prev;
        n_valid   = r_valid && !i_ready;
        n_key     = r_key;
        n_dur     = r_dur;
        n_last    = r_last;
        o_pop     = 1'b0;
        gap_add   = '0;

        case (i_entry.kind)
            mke_pkg::K_SPACE: gap_add = u7;
            default:          gap_add = r_prev ? {1'b0, u3} : 19'd0;
        endcase
        gap_sum = SW'(r_pending) + SW'(gap_add);

        case (r_state)
            mke_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cur = i_entry;
                    n_idx = 3'd0;
                    if (r_dot_unit == 16'd0) begin
                        // muted: only end of message has an effect
                        if (i_entry.eom) begin
                            n_pending = '0;
                            n_prev    = 1'b0;
                        end
                    end else begin
                        n_pending = sat(gap_sum);
                        case (i_entry.kind)
                            mke_pkg::K_SYMBOL: begin
                                n_state = mke_pkg::ST_SYM;
                            end
                            default: begin
                                n_prev  = 1'b0;
                                n_state = i_entry.eom ? mke_pkg::ST_FLUSH : mke_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            mke_pkg::ST_SYM: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    if (r_pending != '0) begin
                        // pending gap goes out before the mark
                        n_key     = 1'b0;
                        n_dur     = r_pending;
                        n_last    = 1'b0;
                        n_pending = '0;
                    end else begin
                        n_key  = 1'b1;
                        n_dur  = sat(is_dash ? SW'(u3) : SW'(r_dot_unit));
                        n_last = last_sym;
                        if (last_sym) begin
                            n_prev  = !r_cur.eom;
                            n_state = mke_pkg::ST_IDLE;
                        end else begin
                            n_pending = DB'(r_dot_unit);
                            n_idx     = r_idx + 3'd1;
                        end
                    end
                end
            end

            mke_pkg::ST_FLUSH: begin
                if (r_pending == '0) begin
                    n_prev  = 1'b0;
                    n_state = mke_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_valid   = 1'b1;
                    n_key     = 1'b0;
                    n_dur     = r_pending;
                    n_last    = 1'b1;
                    n_pending = '0;
                    n_prev    = 1'b0;
                    n_state   = mke_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mke_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid    = r_valid;
    assign o_mark     = r_key;
    assign o_duration = r_dur;
    assign o_last     = r_last;

endmodule

/* src/morse_keying_encoder.sv */
// Top level of the Morse keying encoder: front end, queue and keying sequencer.
//
// Each request on the input stream carries one character byte (tlast marks the end of a
// message) and expands into key events on the output stream: tuser is 1 for a mark and 0
// for a gap, tdata holds the duration in ms, tlast flags the final event of that character.
// Letters of either case and digits use International Morse; space adds seven units of gap,
// other bytes add only the letter separator. Gaps accumulate and go out before the next
// mark or at end of message, saturating at 2^DURATION_BITS-1. A dot unit of zero mutes
// all output.
// Rate: the front end queues one character per cycle into a two-entry queue while the queue
// has room. The keying sequencer takes a character from the queue when idle, emits its gap
// and mark events in order (any pending gap before each mark), and finishes each character
// before it takes the next one. A stall on the output holds the sequencer; the front end
// keeps accepting until the queue is full.
module morse_keying_encoder #(
    parameter int DURATION_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: dot_unit
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    // character stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
    input  logic          s_axis_tlast,   // end_of_message
    // key event stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [((DURATION_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
                                          // [DURATION_BITS-1:0] duration, zero fill
    output logic          m_axis_tuser,   // mark flag: 1 mark, 0 gap
    output logic          m_axis_tlast    // last_of_run
);

    localparam int OW = ((DURATION_BITS + 7) / 8) * 8;

    logic                     push;
    logic                     pop;
    logic                     full;
    logic                     empty;
    mke_pkg::t_entry          push_entry;
    mke_pkg::t_entry          pop_entry;
    logic [DURATION_BITS-1:0] duration;

    mke_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_push        (push),
        .o_entry       (push_entry),
        .i_full        (full)
    );

    mke_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    mke_back #(
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_entry    (pop_entry),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_mark     (m_axis_tuser),
        .o_duration (duration),
        .o_last     (m_axis_tlast)
    );

    // Duration in the low bits, zero fill up to a whole byte
    assign m_axis_tdata = OW'(duration);

endmodule

/* test/morse_keying_encoder_tb.sv */
// Testbench for the Morse keying encoder: stream stimulus, event predictor and scoreboard.
`timescale 1ns / 1ps

typedef struct {
    bit        mark;
    bit [31:0] duration;
    bit        last_of_run;
} t_key_event;

// Predicts the key events of each accepted character and checks the output stream
class morse_scoreboard;
    localparam longint unsigned DUR_MAX = 64'h0000_0000_FFFF_FFFF;

    bit [15:0]  dot_unit;
    bit [31:0]  gap_owed;
    bit         after_symbol;
    t_key_event expected_events[$];
    int         errors;

    function new();
        dot_unit     = mke_pkg::DOT_UNIT_RESET;
        gap_owed     = '0;
        after_symbol = 1'b0;
        errors       = 0;
    endfunction

    function void set_unit(bit [15:0] value);
        dot_unit = value;
    endfunction

    function int outstanding();
        return expected_events.size();
    endfunction

    function bit [31:0] clamp_duration(longint unsigned value);
        return (value > DUR_MAX) ? DUR_MAX[31:0] : value[31:0];
    endfunction

    function void owe_gap(longint unsigned units);
        gap_owed = clamp_duration(longint'(gap_owed) + units);
    endfunction

    // Dot/dash string of a letter (either case) or digit, empty when unsupported
    function string morse_of(bit [7:0] ch);
        if (ch >= mke_pkg::CH_LOWER_A && ch <= mke_pkg::CH_LOWER_Z)
            ch = ch - mke_pkg::CASE_DELTA;
        case (ch)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    // Expand one accepted character into the key events it causes
    function void note_char(bit [7:0] ch, bit eom);
        t_key_event      run[$];
        string           code;
        longint unsigned u;
        u = dot_unit;
        if (u != 0) begin
            if (ch == mke_pkg::CH_SPACE) begin
                owe_gap(7 * u);
                after_symbol = 1'b0;
            end else begin
                code = morse_of(ch);
                // letter separator is owed by anything but a space
                if (after_symbol)
                    owe_gap(3 * u);
                after_symbol = (code.len() != 0);
                for (int j = 0; j < code.len(); j++) begin
                    if (gap_owed != 0) begin
                        run.insert(run.size(), '{1'b0, gap_owed, 1'b0});
                        gap_owed = '0;
                    end
                    run.insert(run.size(),
                               '{1'b1, clamp_duration((code[j] == "-") ? 3 * u : u), 1'b0});
                    if (j + 1 < code.len())
                        owe_gap(u);
                end
            end
            if (eom && gap_owed != 0)
                run.insert(run.size(), '{1'b0, gap_owed, 1'b0});
        end
        // end of message clears state even when muted
        if (eom) begin
            gap_owed     = '0;
            after_symbol = 1'b0;
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k])
            expected_events.insert(expected_events.size(), run[k]);
    endfunction

    // Compare one output event against the oldest prediction
    function void check_key_event(bit mark, bit [31:0] duration, bit last_of_run);
        t_key_event want;
        if (expected_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected event mark=%0b duration=%0d last=%0b",
                     $time, mark, duration, last_of_run);
            return;
        end
        want = expected_events.pop_front();
        if (want.mark != mark) begin
            errors++;
            $display("%0t: mark expected %0b actual %0b", $time, want.mark, mark);
        end
        if (want.duration != duration) begin
            errors++;
            $display("%0t: duration expected %0d actual %0d", $time, want.duration, duration);
        end
        if (want.last_of_run != last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last_of_run, last_of_run);
        end
    endfunction
endclass

module morse_keying_encoder_tb;

    localparam int DURATION_BITS    = 32;
    localparam int OUT_BITS         = ((DURATION_BITS + 7) / 8) * 8;
    localparam int SETTLE_CYCLES    = 24;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int LONG_SPACES      = 12;
    localparam int RANDOM_PER_PHASE = 143;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [15:0]         i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] char_code
    logic                s_axis_tlast;   // end_of_message
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;   // [31:0] duration
    logic                m_axis_tuser;   // mark flag
    logic                m_axis_tlast;   // last_of_run

    morse_scoreboard sb;
    int              snd_idle_pct;
    int              rcv_idle_pct;
    bit              hold_off_req;

    morse_keying_encoder #(
        .DURATION_BITS (DURATION_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Output side: random back-pressure plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Check every accepted key event
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
            sb.check_key_event(m_axis_tuser, m_axis_tdata[DURATION_BITS-1:0], m_axis_tlast);
    end

    // Offer one character, with random idle cycles ahead of it
    task automatic send_char(input bit [7:0] ch, input bit eom);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_char(ch, eom);
    endtask

    task automatic send_text(input string text, input bit eom_at_end);
        for (int k = 0; k < text.len(); k++)
            send_char(text[k], eom_at_end && (k == text.len() - 1));
    endtask

    // Stop sending and let every expected event drain
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_unit(input bit [15:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_unit(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly text with words and spaces, some arbitrary bytes
    function automatic bit [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return mke_pkg::CH_UPPER_A + 8'($urandom_range(25));
        if (r < 55)
            return mke_pkg::CH_LOWER_A + 8'($urandom_range(25));
        if (r < 70)
            return mke_pkg::CH_ZERO + 8'($urandom_range(9));
        if (r < 85)
            return mke_pkg::CH_SPACE;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        hold_off_req  = 1'b0;
        snd_idle_pct  = 9;
        rcv_idle_pct  = 63;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset unit, both cases, digits, unsupported bytes, spaces
        send_text("Az09ET", 1'b0);
        send_char(mke_pkg::CH_SPACE, 1'b0);
        send_char("#", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        // space after letter, unsupported after letter, end of message variants
        send_text("K M", 1'b1);
        send_text("R ", 1'b1);
        send_text("Q!", 1'b1);
        send_char("7", 1'b0);
        // muted unit: no events, end of message still clears the separator
        write_unit(16'd0);
        send_text("B9 ", 1'b0);
        send_char("X", 1'b1);
        write_unit(16'd1);
        send_text("5h", 1'b0);
        write_unit(16'hFFFF);
        send_text("0Y", 1'b1);

        // Long pending gap built from spaces with the longest unit
        for (int k = 0; k < LONG_SPACES; k++)
            send_char(mke_pkg::CH_SPACE, 1'b0);
        send_char("E", 1'b1);

        // Random text under three idling patterns and three unit settings
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    write_unit(16'd1);
                    snd_idle_pct = 9;
                    rcv_idle_pct = 63;
                end
                1: begin
                    write_unit(16'($urandom_range(65535)));
                    snd_idle_pct = 63;
                    rcv_idle_pct = 9;
                end
                default: begin
                    write_unit(16'hFFFF);
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (p == 0 && k == 40)
                    hold_off_req = 1'b1;
                send_char(pick_char(), $urandom_range(11) == 0);
            end
        end

        wait_quiet();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[morse_keying_encoder] OK");
        else
            $display("[morse_keying_encoder] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("[morse_keying_encoder] ERROR");
        $finish;
    end
endmodule
